/* rtl/core/array_deque_assert.svh */
// Assertion macros for the array deque RTL.
// Uses the enclosing module's clk and rst_n; no other dependencies.
`ifndef ARRAY_DEQUE_ASSERT_SVH
`define ARRAY_DEQUE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define AD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array_deque: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define AD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array_deque: next-cycle check failed");
`else
`define AD_ASSERT_NOW(lbl, ante, cons)
`define AD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/ad_pkg.sv */
// Shared types and constants for the array deque.
// No dependencies.
`timescale 1ns / 1ps

package ad_pkg;

  localparam int DEPTH  = 8;
  localparam int WORD_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // One extra bit so an index can hold minus one.
  localparam int IDX_W  = ADDR_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] NONE_IDX = '1;

  typedef enum logic [1:0] {
    ACT_PUSH_REAR  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_REAR   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    act_t                     action;
    logic signed [WORD_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;
    logic                     is_empty;
    logic                     is_full;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WB   = 2'd2
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input beat
    logic exec;         // perform the latched operation
    logic load_direct;  // load output from this cycle's push result
    logic load_pend;    // load output from the pending result
  } ad_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_pop;
  } ad_stat_t;

endpackage

/* rtl/core/ad_ctrl.sv */
// Controller FSM for the array deque: sequences capture, execute, write-back.
// Depends on ad_pkg.
`timescale 1ns / 1ps

module ad_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ad_pkg::ad_stat_t stat,
  output ad_pkg::ad_cmd_t  cmd
);
  import ad_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!stat.is_pop && slot_free) begin
          cmd.load_direct = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (slot_free) begin
          cmd.load_pend = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.load_direct || cmd.load_pend) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/ad_dpath.sv */
// Datapath for the array deque: indices, storage array, result registers.
// Depends on ad_pkg.
`timescale 1ns / 1ps

module ad_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  ad_pkg::in_beat_t  in_data,
  input  ad_pkg::ad_cmd_t   cmd,
  output ad_pkg::ad_stat_t  stat,
  output ad_pkg::out_beat_t out_data
);
  import ad_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  in_beat_t          item_r;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  rear_r, rear_nxt;
  logic [WORD_W-1:0] rd_data_r;
  status_t           pend_status_r;
  logic              pend_empty_r;
  logic              pend_full_r;
  out_beat_t         out_data_r;

  status_t           status_c;
  logic              wr_en_c;
  logic [ADDR_W-1:0] wr_addr_c;
  logic [ADDR_W-1:0] rd_addr_c;
  logic              empty_c;
  logic              full_c;
  logic              is_pop;

  assign is_pop      = item_r.action inside {ACT_POP_REAR, ACT_POP_FRONT};
  assign stat.is_pop = is_pop;

  // Evaluate the latched operation against the current indices.
  always_comb begin
    status_c  = ST_OK;
    front_nxt = front_r;
    rear_nxt  = rear_r;
    wr_en_c   = 1'b0;
    wr_addr_c = rear_r[ADDR_W-1:0];
    rd_addr_c = rear_r[ADDR_W-1:0];
    case (item_r.action)
      ACT_PUSH_REAR: begin
        if (rear_r == LAST_IDX) begin
          status_c = ST_FULL;
        end else begin
          rear_nxt  = rear_r + IDX_W'(1);
          wr_en_c   = 1'b1;
          wr_addr_c = rear_nxt[ADDR_W-1:0];
        end
      end
      ACT_PUSH_FRONT: begin
        if (rear_r == LAST_IDX || front_r == NONE_IDX) begin
          status_c = ST_FULL;
        end else begin
          wr_en_c   = 1'b1;
          wr_addr_c = front_r[ADDR_W-1:0];
          front_nxt = front_r - IDX_W'(1);
        end
      end
      ACT_POP_REAR: begin
        if (front_r == rear_r) begin
          status_c = ST_EMPTY;
        end else begin
          rd_addr_c = rear_r[ADDR_W-1:0];
          rear_nxt  = rear_r - IDX_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (front_r == rear_r) begin
          status_c = ST_EMPTY;
        end else begin
          front_nxt = front_r + IDX_W'(1);
          rd_addr_c = front_nxt[ADDR_W-1:0];
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
    empty_c = (front_nxt == rear_nxt);
    full_c  = (rear_nxt == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= NONE_IDX;
      rear_r  <= NONE_IDX;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  // Storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en_c) begin
      mem[wr_addr_c] <= item_r.push_value;
    end
    if (cmd.exec) begin
      rd_data_r <= mem[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.exec) begin
      pend_status_r <= status_c;
      pend_empty_r  <= empty_c;
      pend_full_r   <= full_c;
    end
    if (cmd.load_direct) begin
      out_data_r.pop_value <= '0;
      out_data_r.status    <= status_c;
      out_data_r.is_empty  <= empty_c;
      out_data_r.is_full   <= full_c;
    end else if (cmd.load_pend) begin
      if (pend_status_r == ST_EMPTY) begin
        out_data_r.pop_value <= '1;
      end else if (is_pop) begin
        out_data_r.pop_value <= rd_data_r;
      end else begin
        out_data_r.pop_value <= '0;
      end
      out_data_r.status   <= pend_status_r;
      out_data_r.is_empty <= pend_empty_r;
      out_data_r.is_full  <= pend_full_r;
    end
  end

  assign out_data = out_data_r;

endmodule

/* rtl/core/array_deque.sv */
// Top level of the array deque: controller plus datapath, with port checks.
// Depends on ad_pkg, ad_ctrl, ad_dpath and array_deque_assert.svh.
`timescale 1ns / 1ps

// Double-ended queue of DEPTH signed 32-bit words held in a linear array that
// never wraps. Each input beat carries one action (push rear, push front, pop
// rear, pop front) and yields exactly one output beat with the popped word,
// a status (ok, full, empty) and the empty/full flags after the step. A
// refused pop returns -1, every push returns 0. Front pushes need a free slot
// below the front index, so a queue filled only from the rear refuses them.
// A free output register is loaded with a push result from the execute state;
// a pop always passes the write-back state, which holds the registered read.
// The next input beat is accepted in the cycle after the result is loaded,
// so the block takes no new item before the last result is loaded. A held
// output beat stalls the write-back, and the input side with it: no new beat is
// accepted until the pending result is loaded. Storage is not cleared at reset,
// which is harmless since only written slots are ever returned by a pop.
module array_deque (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ad_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ad_pkg::out_beat_t out_data
);
  import ad_pkg::*;

`include "array_deque_assert.svh"

  ad_cmd_t  cmd;
  ad_stat_t stat;

  // Sequence each beat: capture, execute, then load the result (from execute or
  // write-back) when the output register is free.
  ad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the indices, the storage array and the result registers.
  ad_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // A captured beat is always executed in the following cycle.
  `AD_ASSERT_NEXT(a_capture_then_exec, cmd.capture, cmd.exec)
  // No new beat is accepted while an operation is executing.
  `AD_ASSERT_NOW(a_no_accept_in_exec, cmd.exec, !in_ready)
  // Never overwrite an output beat that is still held.
  `AD_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready,
                 !(cmd.load_direct || cmd.load_pend))
  // Only one result source loads the output register at a time.
  `AD_ASSERT_NOW(a_one_load, cmd.load_direct, !cmd.load_pend)

endmodule
